/* sv/rcwr_pkg.sv */
// package for the rolling code window responder
// holds code widths, status codes and the code generator function; no dependencies
package rcwr_pkg;

  localparam int unsigned CODE_BITS = 23;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned SHIFT_W   = 13;
  localparam int unsigned SEED_W    = 23;

  localparam logic [SEED_W-1:0]    SEED_RESET = SEED_W'(425);
  localparam logic [6:0]           LCG_MUL    = 7'd107;
  localparam logic [CODE_BITS-1:0] LCG_ADD    = CODE_BITS'(11);

  typedef enum logic [STATUS_W-1:0] {
    ST_RESTART   = 3'd0,
    ST_ZERO      = 3'd1,
    ST_NOT_READY = 3'd2,
    ST_NO_MATCH  = 3'd3,
    ST_REPEAT    = 3'd4,
    ST_RESYNC    = 3'd5
  } status_e;

  // next code: (107*x mod 2^CODE_BITS + 11) mod 2^CODE_BITS
  function automatic logic [CODE_BITS-1:0] lcg(input logic [CODE_BITS-1:0] x);
    logic [CODE_BITS+6:0] prod;
    prod = {7'b0, x} * {{CODE_BITS{1'b0}}, LCG_MUL};
    return prod[CODE_BITS-1:0] + LCG_ADD;
  endfunction

endpackage

/* sv/rcwr_item_if.sv */
// input channel of the rolling code window responder
// valid/ready handshake with kind and code payload; depends on rcwr_pkg
interface rcwr_item_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [rcwr_pkg::CODE_BITS-1:0] code;

  modport source (output valid, output kind, output code, input ready);
  modport sink   (input valid, input kind, input code, output ready);
endinterface

/* sv/rcwr_result_if.sv */
// result channel of the rolling code window responder
// valid/ready handshake with one result per transaction; depends on rcwr_pkg
interface rcwr_result_if;
  logic                           valid;
  logic                           ready;
  logic                           send;
  logic [rcwr_pkg::CODE_BITS-1:0] rolling_code;
  logic [rcwr_pkg::CODE_BITS-1:0] challenge;
  logic [rcwr_pkg::STATUS_W-1:0]  status;
  logic [rcwr_pkg::SHIFT_W-1:0]   shift_count;

  modport source (output valid, output send, output rolling_code, output challenge,
                  output status, output shift_count, input ready);
  modport sink   (input valid, input send, input rolling_code, input challenge,
                  input status, input shift_count, output ready);
endinterface

/* sv/rcwr_ram.sv */
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module rcwr_ram #(
  parameter int unsigned WIDTH = 23,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/rolling_code_window_responder.sv */
// rolling code window responder: a restart fills the window, a rejected or not ready
// code goes straight to the result, a miss reads the whole window and a match at
// window position p drops p+2 codes; one item is in work at a time and the next is
// taken as soon as the result sits in the output register; outside a result stall
// the rate is set by one window memory access per cycle; the window memory is not
// cleared by reset (async active low reset clears control, head, codes and seed to 425)
module rolling_code_window_responder #(
  parameter int unsigned WINDOW = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  rcwr_item_if.sink             item_i,
  rcwr_result_if.source         result_o
);
  import rcwr_pkg::*;

  localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CW = $clog2(WINDOW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RST_A, S_RST_B, S_FILL, S_SEARCH, S_DROP,
    S_RD_FRONT, S_RD_WAIT, S_DROP_LAST, S_EMIT
  } state_e;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
    return (a == AW'(WINDOW - 1)) ? '0 : a + AW'(1);
  endfunction

  state_e               state_q;
  logic [SEED_W-1:0]    seed_q;
  logic [CODE_BITS-1:0] code_q, tail_q, chal_q, roll_q;
  logic [AW-1:0]        head_q, raddr_q, cmp_idx_q;
  logic [CW-1:0]        idx_q, drop_cnt_q;
  logic                 ready_q, cmp_vld_q, send_q;
  status_e              status_q;
  logic [SHIFT_W-1:0]   shift_q;

  logic                 out_vld_q, out_send_q;
  logic [CODE_BITS-1:0] out_roll_q, out_chal_q;
  status_e              out_status_q;
  logic [SHIFT_W-1:0]   out_shift_q;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [CODE_BITS-1:0] ram_rdata, lcg_next;
  logic                 item_acc, cfg_wr, out_free;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == 1'b0) ? 32'(seed_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SEED_RESET;
    end else if (cfg_wr && paddr[2] == 1'b0) begin
      seed_q <= pwdata[SEED_W-1:0];
    end
  end

  // window memory
  assign lcg_next = lcg(tail_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = head_q;
    ram_raddr = head_q;
    unique case (state_q)
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
      end
      S_DROP, S_DROP_LAST: begin
        ram_we = 1'b1;
      end
      S_SEARCH: begin
        ram_raddr = raddr_q;
      end
      default: begin
      end
    endcase
  end

  rcwr_ram #(
    .WIDTH (CODE_BITS),
    .DEPTH (WINDOW)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (lcg_next),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // handshakes
  assign item_i.ready = (state_q == S_IDLE);
  assign item_acc     = item_i.valid && (state_q == S_IDLE);
  assign out_free     = !out_vld_q || result_o.ready;

  assign result_o.valid        = out_vld_q;
  assign result_o.send         = out_send_q;
  assign result_o.rolling_code = out_roll_q;
  assign result_o.challenge    = out_chal_q;
  assign result_o.status       = out_status_q;
  assign result_o.shift_count  = out_shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      code_q       <= '0;
      tail_q       <= '0;
      chal_q       <= '0;
      roll_q       <= '0;
      head_q       <= '0;
      raddr_q      <= '0;
      cmp_idx_q    <= '0;
      idx_q        <= '0;
      drop_cnt_q   <= '0;
      ready_q      <= 1'b0;
      cmp_vld_q    <= 1'b0;
      send_q       <= 1'b0;
      status_q     <= ST_RESTART;
      shift_q      <= '0;
      out_vld_q    <= 1'b0;
      out_send_q   <= 1'b0;
      out_roll_q   <= '0;
      out_chal_q   <= '0;
      out_status_q <= ST_RESTART;
      out_shift_q  <= '0;
    end else begin
      if (out_vld_q && result_o.ready && state_q != S_EMIT) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (item_acc) begin
            code_q  <= item_i.code;
            send_q  <= 1'b0;
            shift_q <= '0;
            if (item_i.kind == 1'b0) begin
              tail_q  <= seed_q;
              state_q <= S_RST_A;
            end else if (!ready_q) begin
              status_q <= ST_NOT_READY;
              state_q  <= S_EMIT;
            end else if (item_i.code == '0) begin
              status_q <= ST_ZERO;
              state_q  <= S_EMIT;
            end else begin
              idx_q     <= '0;
              raddr_q   <= head_q;
              cmp_vld_q <= 1'b0;
              state_q   <= S_SEARCH;
            end
          end
        end
        S_RST_A: begin
          tail_q  <= lcg_next;
          state_q <= S_RST_B;
        end
        S_RST_B: begin
          tail_q  <= lcg_next;
          chal_q  <= lcg_next;
          idx_q   <= '0;
          state_q <= S_FILL;
        end
        S_FILL: begin
          tail_q <= lcg_next;
          idx_q  <= idx_q + CW'(1);
          if (idx_q == '0) begin
            roll_q <= lcg_next;
          end
          if (idx_q == CW'(WINDOW - 1)) begin
            head_q   <= '0;
            ready_q  <= 1'b1;
            status_q <= ST_RESTART;
            state_q  <= S_EMIT;
          end
        end
        S_SEARCH: begin
          if (idx_q < CW'(WINDOW)) begin
            idx_q     <= idx_q + CW'(1);
            raddr_q   <= wrap_inc(raddr_q);
            cmp_vld_q <= 1'b1;
            cmp_idx_q <= idx_q[AW-1:0];
          end else begin
            cmp_vld_q <= 1'b0;
          end
          if (cmp_vld_q && ram_rdata == code_q) begin
            chal_q     <= code_q;
            shift_q    <= SHIFT_W'(cmp_idx_q) + SHIFT_W'(2);
            drop_cnt_q <= CW'(cmp_idx_q) + CW'(1);
            send_q     <= 1'b1;
            status_q   <= ST_RESYNC;
            state_q    <= S_DROP;
          end else if (cmp_vld_q && cmp_idx_q == AW'(WINDOW - 1)) begin
            if (code_q == chal_q) begin
              send_q   <= 1'b1;
              status_q <= ST_REPEAT;
            end else begin
              status_q <= ST_NO_MATCH;
            end
            state_q <= S_EMIT;
          end
        end
        S_DROP: begin
          tail_q     <= lcg_next;
          head_q     <= wrap_inc(head_q);
          drop_cnt_q <= drop_cnt_q - CW'(1);
          if (drop_cnt_q == CW'(1)) begin
            state_q <= S_RD_FRONT;
          end
        end
        S_RD_FRONT: begin
          state_q <= S_RD_WAIT;
        end
        S_RD_WAIT: begin
          roll_q  <= ram_rdata;
          state_q <= S_DROP_LAST;
        end
        S_DROP_LAST: begin
          tail_q  <= lcg_next;
          head_q  <= wrap_inc(head_q);
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_vld_q    <= 1'b1;
            out_send_q   <= send_q;
            out_roll_q   <= roll_q;
            out_chal_q   <= chal_q;
            out_status_q <= status_q;
            out_shift_q  <= shift_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/rcwr_checker.sv */
// port level checks for the rolling code window responder
// bound to rolling_code_window_responder; depends on rcwr_pkg
module rcwr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic                           send_i,
  input logic [rcwr_pkg::CODE_BITS-1:0] rolling_code_i,
  input logic [rcwr_pkg::CODE_BITS-1:0] challenge_i,
  input logic [rcwr_pkg::STATUS_W-1:0]  status_i,
  input logic [rcwr_pkg::SHIFT_W-1:0]   shift_count_i
);
  import rcwr_pkg::*;

  logic [1:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // transactions accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(rolling_code_i)
      && $stable(challenge_i) && $stable(status_i) && $stable(shift_count_i))
    else $error("result changed while stalled");

  a_send_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> send_i == (status_i == ST_RESYNC || status_i == ST_REPEAT))
    else $error("send does not match status");

  a_shift_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((status_i == ST_RESYNC) ? (shift_count_i >= SHIFT_W'(2))
                                             : (shift_count_i == '0)))
    else $error("shift count does not match status");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc |-> pend_q != 2'd0) and (pend_q <= 2'd2))
    else $error("result without pending transaction");

endmodule

bind rolling_code_window_responder rcwr_checker u_rcwr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (item_i.valid),
  .in_ready_i     (item_i.ready),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .send_i         (result_o.send),
  .rolling_code_i (result_o.rolling_code),
  .challenge_i    (result_o.challenge),
  .status_i       (result_o.status),
  .shift_count_i  (result_o.shift_count)
);

/* dv/rolling_code_window_responder_tb.sv */
// testbench for rolling_code_window_responder: directed and random transactions
// checked against an in-bench predictor; needs rcwr_pkg, rcwr_item_if, rcwr_result_if
`timescale 1ns / 100ps
module rolling_code_window_responder_tb;
  import rcwr_pkg::*;

  localparam int WIN = 256;
  localparam int PHASE_ITEMS = 238;
  localparam int HOLD_CYCLES = 3000;
  localparam int GEN_MUL = 107;
  localparam int GEN_ADD = 11;
  localparam logic KIND_RESTART = 1'b0;
  localparam logic KIND_CODE = 1'b1;
  localparam logic [2:0] SEED_ADDR = 3'd0;

  typedef struct packed {
    logic                 send;
    logic [CODE_BITS-1:0] rolling;
    logic [CODE_BITS-1:0] chal;
    status_e              status;
    logic [SHIFT_W-1:0]   shifts;
  } answer_t;

  class code_window_board;
    logic [CODE_BITS-1:0] ring [WIN];
    int                   head;
    logic [CODE_BITS-1:0] tail;
    logic [CODE_BITS-1:0] chal;
    logic [CODE_BITS-1:0] rolling;
    logic [SEED_W-1:0]    seed;
    bit                   armed;
    answer_t              pending_answers [$];
    int                   tally [6];
    int                   deepest;
    int                   errors;

    function new();
      head = 0;
      tail = '0;
      chal = '0;
      rolling = '0;
      seed = SEED_W'(425);
      armed = 1'b0;
      deepest = 0;
      errors = 0;
      foreach (tally[i]) tally[i] = 0;
    endfunction

    function logic [CODE_BITS-1:0] next_code(input logic [CODE_BITS-1:0] x);
      return x * CODE_BITS'(GEN_MUL) + CODE_BITS'(GEN_ADD);
    endfunction

    function void drop_front();
      tail = next_code(tail);
      ring[head] = tail;
      head = (head + 1) % WIN;
    endfunction

    function logic [CODE_BITS-1:0] code_at(input int pos);
      return ring[(head + pos) % WIN];
    endfunction

    function int outstanding();
      return pending_answers.size();
    endfunction

    function void take_item(input logic kind, input logic [CODE_BITS-1:0] code);
      answer_t a;
      int      pos;
      bit      hit;
      a.send = 1'b0;
      a.shifts = '0;
      hit = 1'b0;
      pos = 0;
      if (kind == KIND_RESTART) begin
        chal = next_code(next_code(seed));
        tail = chal;
        for (int i = 0; i < WIN; i++) begin
          tail = next_code(tail);
          ring[i] = tail;
        end
        head = 0;
        rolling = ring[0];
        armed = 1'b1;
        a.status = ST_RESTART;
      end else if (!armed) begin
        a.status = ST_NOT_READY;
      end else if (code == '0) begin
        a.status = ST_ZERO;
      end else begin
        for (int i = 0; i < WIN && !hit; i++) begin
          if (code_at(i) == code) begin
            hit = 1'b1;
            pos = i;
          end
        end
        if (hit) begin
          for (int i = 0; i < pos; i++) drop_front();
          chal = ring[head];
          drop_front();
          rolling = ring[head];
          drop_front();
          a.shifts = SHIFT_W'(pos + 2);
          a.send = 1'b1;
          a.status = ST_RESYNC;
          if (pos + 2 > deepest) deepest = pos + 2;
        end else if (code == chal) begin
          a.send = 1'b1;
          a.status = ST_REPEAT;
        end else begin
          a.status = ST_NO_MATCH;
        end
      end
      a.rolling = rolling;
      a.chal = chal;
      tally[int'(a.status)]++;
      pending_answers = {pending_answers, a};
    endfunction

    function void field_ok(input string name, input logic [31:0] e, input logic [31:0] a);
      if (a !== e) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_answer(input logic send, input logic [CODE_BITS-1:0] roll,
                               input logic [CODE_BITS-1:0] ch, input logic [STATUS_W-1:0] st,
                               input logic [SHIFT_W-1:0] sh);
      answer_t e;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result, expected none actual status %0d code %0h",
                 $time, st, roll);
        errors++;
      end else begin
        e = pending_answers.pop_front();
        field_ok("send", 32'(e.send), 32'(send));
        field_ok("rolling_code", 32'(e.rolling), 32'(roll));
        field_ok("challenge", 32'(e.chal), 32'(ch));
        field_ok("status", 32'(e.status), 32'(st));
        field_ok("shift_count", 32'(e.shifts), 32'(sh));
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_request;
  int hold_left;

  code_window_board board = new();

  rcwr_item_if   items();
  rcwr_result_if answers();

  rolling_code_window_responder #(.WINDOW(WIN)) uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .item_i   (items),
    .result_o (answers)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    answers.ready = 1'b0;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        answers.ready <= 1'b0;
        hold_left--;
      end else begin
        answers.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && answers.valid && answers.ready)
      board.check_answer(answers.send, answers.rolling_code, answers.challenge,
                         answers.status, answers.shift_count);
  end

  initial begin
    #25_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic offer_item(input logic kind, input logic [CODE_BITS-1:0] code);
    int idle;
    idle = 0;
    while (idle < 8 && $urandom_range(99) < send_idle_pct) idle++;
    if (idle != 0) begin
      items.valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    items.valid <= 1'b1;
    items.kind <= kind;
    items.code <= code;
    do @(posedge clk_i); while (!items.ready);
    board.take_item(kind, code);
  endtask

  task automatic settle_and_seed(input logic [SEED_W-1:0] value);
    items.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SEED_ADDR;
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(value)) begin
      $display("%0t: seed readback mismatch, expected %0h actual %0h", $time, value, prdata);
      board.errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    board.seed = value;
  endtask

  task automatic run_phase(input logic [SEED_W-1:0] value, input int idle_pct,
                           input int stall_pct, input bit with_hold);
    int pick;
    int pos;
    settle_and_seed(value);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    offer_item(KIND_RESTART, CODE_BITS'($urandom()));
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (with_hold && n == 12) hold_request = 1'b1;
      pick = $urandom_range(99);
      if (pick < 6) begin
        offer_item(KIND_RESTART, CODE_BITS'($urandom()));
      end else if (pick < 62) begin
        if ($urandom_range(99) < 88) pos = $urandom_range(15);
        else pos = $urandom_range(WIN - 1);
        offer_item(KIND_CODE, board.code_at(pos));
      end else if (pick < 72) begin
        offer_item(KIND_CODE, board.chal);
      end else if (pick < 77) begin
        offer_item(KIND_CODE, '0);
      end else begin
        offer_item(KIND_CODE, CODE_BITS'($urandom()));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    items.valid = 1'b0;
    items.kind = KIND_RESTART;
    items.code = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // codes before the first restart, then each outcome with the reset seed
    offer_item(KIND_CODE, '0);
    offer_item(KIND_CODE, '1);
    offer_item(KIND_CODE, CODE_BITS'(1));
    offer_item(KIND_RESTART, '1);
    offer_item(KIND_CODE, '0);
    offer_item(KIND_CODE, board.code_at(0));
    offer_item(KIND_CODE, board.chal);
    offer_item(KIND_CODE, board.code_at(WIN - 1));
    offer_item(KIND_CODE, '1);
    offer_item(KIND_CODE, board.code_at(1));
    offer_item(KIND_CODE, board.chal);
    offer_item(KIND_RESTART, '0);
    offer_item(KIND_CODE, board.code_at(WIN - 2));
    offer_item(KIND_CODE, CODE_BITS'(1));
    offer_item(KIND_CODE, CODE_BITS'(23'h2aaaaa));

    run_phase('0, 0, 0, 1'b0);
    run_phase('1, 57, 0, 1'b0);
    run_phase(SEED_W'($urandom()), 0, 57, 1'b1);
    run_phase(SEED_W'(1), 38, 38, 1'b0);

    items.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (WIN + 16) @(posedge clk_i);

    $display("covered %0d restarts, %0d resyncs (deepest shift %0d), %0d challenge repeats",
             board.tally[ST_RESTART], board.tally[ST_RESYNC], board.deepest,
             board.tally[ST_REPEAT]);
    $display("plus %0d unmatched, %0d zero and %0d early codes over five seeds and a long hold-off",
             board.tally[ST_NO_MATCH], board.tally[ST_ZERO], board.tally[ST_NOT_READY]);
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
